// ----- rtl/core/q2e_pkg.sv -----
package q2e_pkg;

    localparam int QW          = 16;
    localparam int ROLL_W      = 16;
    localparam int PITCH_W     = 15;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 35;
    localparam int SP_W        = 30;
    localparam int MAG_W       = 29;
    localparam int SQ_W        = 57;
    localparam int NPAD_W      = 58;
    localparam int ROOT_W      = 29;
    localparam int REM_W       = 32;
    localparam int SQRT_STEPS  = 29;
    localparam int XY_W        = 38;
    localparam int Z_W         = 35;
    localparam int Q13_W       = 18;
    localparam int PREP_STAGES = 3;
    localparam int CORDIC_MAX  = 32;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    localparam logic signed [Z_W-1:0]   PI_Q30  = 35'sd3373259426;
    localparam logic signed [SUM_W-1:0] ONE_Q28 = 35'sd268435456;
    localparam logic signed [Q13_W-1:0] ROLL_YAW_LIMIT = 18'sd25736;
    localparam logic signed [Q13_W-1:0] PITCH_LIMIT    = 18'sd12868;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SP_W-1:0]  sp;
        logic                    clamped;
    } t_side;

    // atan(2^-i) in Q.30 radians
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 35'sd843314857;
            1:  v = 35'sd497837829;
            2:  v = 35'sd263043837;
            3:  v = 35'sd133525159;
            4:  v = 35'sd67021687;
            5:  v = 35'sd33543516;
            6:  v = 35'sd16775851;
            7:  v = 35'sd8388437;
            8:  v = 35'sd4194283;
            9:  v = 35'sd2097149;
            default: v = (idx < 31) ? (Z_W'(1) <<< (30 - idx)) : '0;
        endcase
        return v;
    endfunction

    // Q.30 radians to Q2.13, rounded, saturated to +-lim
    function automatic logic signed [Q13_W-1:0] to_q13(
        input logic signed [Z_W-1:0]   z,
        input logic signed [Q13_W-1:0] lim
    );
        logic signed [Z_W-1:0]   zr;
        logic signed [Q13_W-1:0] r;
        zr = (z + Z_W'(65536)) >>> 17;
        r  = Q13_W'(zr);
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/q2e_in_if.sv -----
interface q2e_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [q2e_pkg::QW-1:0] quat_w;
    logic signed [q2e_pkg::QW-1:0] quat_x;
    logic signed [q2e_pkg::QW-1:0] quat_y;
    logic signed [q2e_pkg::QW-1:0] quat_z;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- rtl/core/q2e_out_if.sv -----
interface q2e_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [q2e_pkg::ROLL_W-1:0]  roll_angle;
    logic signed [q2e_pkg::PITCH_W-1:0] pitch_angle;
    logic signed [q2e_pkg::ROLL_W-1:0]  yaw_angle;
    logic                               pitch_clamped;

    modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
    modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 output ready);
endinterface

// ----- rtl/core/quaternion_to_euler_core.sv -----
// Channel   Dir  Modport  Payload
// i_quat    in   sink     quat_w, quat_x, quat_y, quat_z (Q1.14)
// o_euler   out  source   roll_angle, yaw_angle (Q2.13), pitch_angle (Q1.13), pitch_clamped
//
// One request per cycle unless the output stalls; the stages are products/sums, one root bit
// per stage, quadrant fold, one CORDIC step per stage (CORDIC_ITERATIONS, capped at 32), output.
// The pipeline advances when the output register is empty or taken; it holds as a whole
// on a stall. Synchronous active-low reset clears the valid bits only.
module quaternion_to_euler_core #(
    parameter int CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    q2e_in_if.sink    i_quat,
    q2e_out_if.source o_euler
);
    localparam int NIT = (CORDIC_ITERATIONS > q2e_pkg::CORDIC_MAX) ?
                         q2e_pkg::CORDIC_MAX : CORDIC_ITERATIONS;
    localparam int LAT = q2e_pkg::PREP_STAGES + q2e_pkg::SQRT_STEPS + 1 + NIT + 1;

    logic                                adv;
    logic [LAT-1:0]                      r_vld;
    logic [q2e_pkg::SQ_W-1:0]            s_n;
    q2e_pkg::t_side                      s_side_p, s_side_q;
    logic [q2e_pkg::ROOT_W-1:0]          s_root;
    logic signed [q2e_pkg::Z_W-1:0]      z_roll, z_pitch, z_yaw;
    logic [NIT:0]                        r_clp;
    logic signed [q2e_pkg::ROLL_W-1:0]   r_roll, r_yaw;
    logic signed [q2e_pkg::PITCH_W-1:0]  r_pitch;
    logic                                r_clamped;

    assign adv          = !r_vld[LAT-1] || o_euler.ready;
    assign i_quat.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    q2e_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_w    (i_quat.quat_w),
        .i_x    (i_quat.quat_x),
        .i_y    (i_quat.quat_y),
        .i_z    (i_quat.quat_z),
        .o_n    (s_n),
        .o_side (s_side_p)
    );

    q2e_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_n    (s_n),
        .i_side (s_side_p),
        .o_root (s_root),
        .o_side (s_side_q)
    );

    q2e_cordic #(.ITER(NIT)) u_roll (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_y   (s_side_q.sr),
        .i_x   (s_side_q.cr),
        .o_z   (z_roll)
    );

    q2e_cordic #(.ITER(NIT)) u_pitch (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_y   (q2e_pkg::SUM_W'(s_side_q.sp)),
        .i_x   (q2e_pkg::SUM_W'({1'b0, s_root})),
        .o_z   (z_pitch)
    );

    q2e_cordic #(.ITER(NIT)) u_yaw (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_y   (s_side_q.sy),
        .i_x   (s_side_q.cy),
        .o_z   (z_yaw)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_clp     <= {r_clp[NIT-1:0], s_side_q.clamped};
            r_roll    <= q2e_pkg::ROLL_W'(q2e_pkg::to_q13(z_roll, q2e_pkg::ROLL_YAW_LIMIT));
            r_pitch   <= q2e_pkg::PITCH_W'(q2e_pkg::to_q13(z_pitch, q2e_pkg::PITCH_LIMIT));
            r_yaw     <= q2e_pkg::ROLL_W'(q2e_pkg::to_q13(z_yaw, q2e_pkg::ROLL_YAW_LIMIT));
            r_clamped <= r_clp[NIT];
        end
    end

    assign o_euler.valid         = r_vld[LAT-1];
    assign o_euler.roll_angle    = r_roll;
    assign o_euler.pitch_angle   = r_pitch;
    assign o_euler.yaw_angle     = r_yaw;
    assign o_euler.pitch_clamped = r_clamped;

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_quat.ready == (!o_euler.valid || o_euler.ready))
        else $error("ready does not follow output stage");

    a_pitch_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.pitch_angle <= 15'sd12868 &&
                           o_euler.pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    a_roll_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.roll_angle <= 16'sd25736 &&
                           o_euler.roll_angle >= -16'sd25736))
        else $error("roll out of range");

    a_yaw_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.yaw_angle <= 16'sd25736 &&
                           o_euler.yaw_angle >= -16'sd25736))
        else $error("yaw out of range");
endmodule

// ----- rtl/core/q2e_prep.sv -----
module q2e_prep (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [q2e_pkg::QW-1:0]     i_w,
    input  logic signed [q2e_pkg::QW-1:0]     i_x,
    input  logic signed [q2e_pkg::QW-1:0]     i_y,
    input  logic signed [q2e_pkg::QW-1:0]     i_z,
    output logic        [q2e_pkg::SQ_W-1:0]   o_n,
    output q2e_pkg::t_side                    o_side
);
    localparam int PW = q2e_pkg::PROD_W;
    localparam int SW = q2e_pkg::SUM_W;

    logic signed [PW-1:0] e_w, e_x, e_y, e_z;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_xz;
    logic signed [SW-1:0] n_sp;
    q2e_pkg::t_side       n_side, r_side2, r_side3;
    logic [q2e_pkg::MAG_W-1:0] n_mag, r_mag;
    logic [q2e_pkg::SQ_W-1:0]  n_sq, r_n;

    assign e_w = PW'(i_w);
    assign e_x = PW'(i_x);
    assign e_y = PW'(i_y);
    assign e_z = PW'(i_z);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= e_w * e_x;
            r_yz <= e_y * e_z;
            r_xx <= e_x * e_x;
            r_yy <= e_y * e_y;
            r_wz <= e_w * e_z;
            r_xy <= e_x * e_y;
            r_zz <= e_z * e_z;
            r_wy <= e_w * e_y;
            r_xz <= e_x * e_z;
        end
    end

    always_comb begin
        n_side.sr = (SW'(r_wx) + SW'(r_yz)) <<< 1;
        n_side.cr = q2e_pkg::ONE_Q28 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
        n_side.sy = (SW'(r_wz) + SW'(r_xy)) <<< 1;
        n_side.cy = q2e_pkg::ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        n_sp      = (SW'(r_wy) - SW'(r_xz)) <<< 1;
        n_side.clamped = 1'b0;
        if (n_sp > q2e_pkg::ONE_Q28) begin
            n_sp = q2e_pkg::ONE_Q28;
            n_side.clamped = 1'b1;
        end else if (n_sp < -q2e_pkg::ONE_Q28) begin
            n_sp = -q2e_pkg::ONE_Q28;
            n_side.clamped = 1'b1;
        end
        n_side.sp = q2e_pkg::SP_W'(n_sp);
        n_mag     = n_sp[SW-1] ? q2e_pkg::MAG_W'(-n_sp) : q2e_pkg::MAG_W'(n_sp);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side2 <= n_side;
            r_mag   <= n_mag;
        end
    end

    assign n_sq = q2e_pkg::SQ_W'(r_mag) * q2e_pkg::SQ_W'(r_mag);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n     <= (q2e_pkg::SQ_W'(1) << (q2e_pkg::SQ_W - 1)) - n_sq;
            r_side3 <= r_side2;
        end
    end

    assign o_n    = r_n;
    assign o_side = r_side3;
endmodule

// ----- rtl/core/q2e_sqrt.sv -----
module q2e_sqrt (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic        [q2e_pkg::SQ_W-1:0]    i_n,
    input  q2e_pkg::t_side                     i_side,
    output logic        [q2e_pkg::ROOT_W-1:0]  o_root,
    output q2e_pkg::t_side                     o_side
);
    localparam int NS = q2e_pkg::SQRT_STEPS;
    localparam int NW = q2e_pkg::NPAD_W;
    localparam int RW = q2e_pkg::REM_W;
    localparam int TW = q2e_pkg::ROOT_W;

    logic [RW-1:0]  c_rem  [0:NS];
    logic [TW-1:0]  c_root [0:NS];
    logic [NW-1:0]  c_npad [0:NS];
    q2e_pkg::t_side c_side [0:NS];

    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_npad[0] = NW'(i_n);
    assign c_side[0] = i_side;

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [RW-1:0]  n_rem, n_sh, n_trial;
        logic [TW-1:0]  n_root;
        logic [RW-1:0]  r_rem;
        logic [TW-1:0]  r_root;
        logic [NW-1:0]  r_npad;
        q2e_pkg::t_side r_side;

        always_comb begin
            n_sh    = {c_rem[k][RW-3:0], c_npad[k][NW-1:NW-2]};
            n_trial = {1'b0, c_root[k], 2'b01};
            if (n_sh >= n_trial) begin
                n_rem  = n_sh - n_trial;
                n_root = {c_root[k][TW-2:0], 1'b1};
            end else begin
                n_rem  = n_sh;
                n_root = {c_root[k][TW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_npad <= c_npad[k] << 2;
                r_side <= c_side[k];
            end
        end

        assign c_rem[k+1]  = r_rem;
        assign c_root[k+1] = r_root;
        assign c_npad[k+1] = r_npad;
        assign c_side[k+1] = r_side;
    end

    assign o_root = c_root[NS];
    assign o_side = c_side[NS];
endmodule

// ----- rtl/core/q2e_cordic.sv -----
module q2e_cordic #(
    parameter int ITER = q2e_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [q2e_pkg::SUM_W-1:0]  i_y,
    input  logic signed [q2e_pkg::SUM_W-1:0]  i_x,
    output logic signed [q2e_pkg::Z_W-1:0]    o_z
);
    localparam int XW = q2e_pkg::XY_W;
    localparam int ZW = q2e_pkg::Z_W;

    logic signed [XW-1:0] c_x [0:ITER];
    logic signed [XW-1:0] c_y [0:ITER];
    logic signed [ZW-1:0] c_z [0:ITER];
    logic                 c_zero [0:ITER];

    logic signed [XW-1:0] e_x, e_y;
    logic signed [XW-1:0] r_x0, r_y0;
    logic signed [ZW-1:0] r_z0;
    logic                 r_zero0;

    assign e_x = XW'(i_x);
    assign e_y = XW'(i_y);

    // quadrant fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero0 <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x0 <= -e_x;
                r_y0 <= -e_y;
                r_z0 <= (i_y >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
            end else begin
                r_x0 <= e_x;
                r_y0 <= e_y;
                r_z0 <= '0;
            end
        end
    end

    assign c_x[0]    = r_x0;
    assign c_y[0]    = r_y0;
    assign c_z[0]    = r_z0;
    assign c_zero[0] = r_zero0;

    for (genvar i = 0; i < ITER; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ANG = q2e_pkg::atan_q30(i);
        logic signed [XW-1:0] r_x, r_y;
        logic signed [ZW-1:0] r_z;
        logic                 r_zero;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero <= c_zero[i];
                if (c_y[i] >= 0) begin
                    r_x <= c_x[i] + (c_y[i] >>> i);
                    r_y <= c_y[i] - (c_x[i] >>> i);
                    r_z <= c_z[i] + ANG;
                end else begin
                    r_x <= c_x[i] - (c_y[i] >>> i);
                    r_y <= c_y[i] + (c_x[i] >>> i);
                    r_z <= c_z[i] - ANG;
                end
            end
        end

        assign c_x[i+1]    = r_x;
        assign c_y[i+1]    = r_y;
        assign c_z[i+1]    = r_z;
        assign c_zero[i+1] = r_zero;
    end

    assign o_z = c_zero[ITER] ? '0 : c_z[ITER];
endmodule
